/* rtl/cbas_pkg.sv */
// shared types and constants of the capacitor bank autoset sequencer
package cbas_pkg;

	localparam int DEFAULT_NUM_BANKS = 16;

	localparam int TIMER_W = 4;
	localparam logic [TIMER_W-1:0] TIMER_SETTLE = TIMER_W'(5);
	localparam logic [TIMER_W-1:0] TIMER_MEASURE = TIMER_W'(8);

	localparam logic [7:0] VALUE_CAP = 8'd250;
	localparam logic [7:0] LARGE_LIMIT = 8'd125;
	localparam logic [4:0] COUNT_MAX = 5'd31;
	localparam logic [2:0] ATTEMPT_LIMIT = 3'd4;

	// commands from the controller, each already qualified by a transfer
	typedef struct packed {
		logic clear;
		logic turn_on;
		logic turn_off;
		logic settle;
		logic finish;
	} cbas_cmd_t;

	// status from the datapath, valid for the measure-off action
	typedef struct packed {
		logic measure_done;
		logic last_bank;
	} cbas_status_t;

	typedef struct packed {
		logic       switch_on;
		logic       switch_off;
		logic       all_off;
		logic [3:0] bank_index;
		logic       value_valid;
		logic [7:0] bank_value;
		logic [7:0] kvar_peak;
		logic [4:0] bank_count;
		logic       done_res;
	} cbas_result_t;

endpackage

/* rtl/cbas_ctrl.sv */
// sequencer controller: run step, tick timer and test phase
module cbas_ctrl
	import cbas_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic         start_req,
	input  cbas_status_t status,
	output cbas_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RUN    = 3'b010,
		ST_FINISH = 3'b100
	} step_t;

	typedef enum logic [2:0] {
		PH_ON     = 3'b001,
		PH_OFF    = 3'b010,
		PH_SETTLE = 3'b100
	} phase_t;

	step_t               step_q, step_d;
	phase_t              phase_q, phase_d;
	logic [TIMER_W-1:0]  timer_q, timer_d;

	always_comb begin
		step_d  = step_q;
		phase_d = phase_q;
		timer_d = timer_q;
		cmd     = '0;
		if (fire) begin
			if (start_req) begin
				cmd.clear = 1'b1;
				step_d    = ST_RUN;
				phase_d   = PH_ON;
				timer_d   = TIMER_SETTLE;
			end else begin
				case (step_q)
					ST_RUN: begin
						if (timer_q != '0) begin
							timer_d = timer_q - TIMER_W'(1);
						end else begin
							case (phase_q)
								PH_ON: begin
									cmd.turn_on = 1'b1;
									timer_d     = TIMER_MEASURE;
									phase_d     = PH_OFF;
								end
								PH_OFF: begin
									cmd.turn_off = 1'b1;
									timer_d      = TIMER_SETTLE;
									phase_d      = status.measure_done ? PH_SETTLE : PH_ON;
									if (status.measure_done && status.last_bank) begin
										step_d = ST_FINISH;
									end
								end
								default: begin
									cmd.settle = 1'b1;
									timer_d    = TIMER_SETTLE;
									phase_d    = PH_ON;
								end
							endcase
						end
					end
					ST_FINISH: begin
						cmd.finish = 1'b1;
						step_d     = ST_IDLE;
					end
					default: begin
						step_d = ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			phase_q <= PH_ON;
			timer_q <= '0;
		end else begin
			step_q  <= step_d;
			phase_q <= phase_d;
			timer_q <= timer_d;
		end
	end

endmodule

/* rtl/cbas_dp.sv */
// sequencer datapath: readings, averaging, bank size, max and count tracking
module cbas_dp
	import cbas_pkg::*;
#(
	parameter int NUM_BANKS = DEFAULT_NUM_BANKS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cbas_cmd_t    cmd,
	input  logic [15:0]  reactive_power,
	input  logic         lagging,
	output cbas_status_t status,
	output cbas_result_t result
);

	localparam int BANK_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam logic [BANK_W-1:0] LAST_BANK = BANK_W'(NUM_BANKS - 1);

	logic [15:0]       before_q, induct_q, capac_q;
	logic [13:0]       sum_q;
	logic [2:0]        attempts_q;
	logic [BANK_W-1:0] bank_q;
	logic [4:0]        counted_q, zrun_q;
	logic [7:0]        largest_q;

	logic [15:0]       induct_n, capac_n, total;
	logic [11:0]       diff;
	logic              diff_zero;
	logic [2:0]        attempts_n;
	logic [13:0]       sum_n;
	logic [11:0]       avg;
	logic [7:0]        value;
	logic [8:0]        doubled;
	logic [7:0]        largest_d;
	logic [4:0]        counted_inc, counted_d, zrun_n;
	logic [BANK_W+3:0] bank_ext;

	// reading taken on either switch action
	assign induct_n = lagging ? reactive_power : induct_q;
	assign capac_n  = lagging ? capac_q : reactive_power;
	assign total    = capac_n + induct_n;

	always_comb begin
		logic [15:0] delta;
		delta = (total > before_q) ? (total - before_q) : (before_q - total);
		diff  = delta[15:4];
	end

	assign diff_zero  = (diff == '0);
	// a zero reading costs two extra attempts
	assign attempts_n = attempts_q + {diff_zero, 1'b0} + 3'd1;
	assign sum_n      = sum_q + {2'b00, diff};
	assign avg        = sum_n[13:2];
	assign value      = (avg > {4'b0000, VALUE_CAP}) ? VALUE_CAP : avg[7:0];
	assign doubled    = {value, 1'b0};

	assign status.measure_done = (attempts_n >= ATTEMPT_LIMIT);
	assign status.last_bank    = (bank_q == LAST_BANK);

	assign counted_inc = (counted_q == COUNT_MAX) ? COUNT_MAX : counted_q + 5'd1;
	// run of zero-valued banks at the top of the table, bank zero never trimmed
	assign zrun_n = (value == '0 && bank_q != '0) ? zrun_q + 5'd1 : '0;

	always_comb begin
		largest_d = largest_q;
		counted_d = counted_q;
		if (cmd.clear) begin
			largest_d = '0;
			counted_d = '0;
		end else if (cmd.turn_off && status.measure_done) begin
			if ({1'b0, largest_q} < doubled) begin
				largest_d = (value < LARGE_LIMIT) ? doubled[7:0] : '0;
			end
			counted_d = counted_inc;
			if (status.last_bank) begin
				counted_d = (counted_inc > zrun_n) ? counted_inc - zrun_n : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			before_q   <= '0;
			induct_q   <= '0;
			capac_q    <= '0;
			sum_q      <= '0;
			attempts_q <= '0;
			bank_q     <= '0;
			counted_q  <= '0;
			zrun_q     <= '0;
			largest_q  <= '0;
		end else begin
			largest_q <= largest_d;
			counted_q <= counted_d;
			if (cmd.clear) begin
				before_q   <= '0;
				induct_q   <= '0;
				capac_q    <= '0;
				sum_q      <= '0;
				attempts_q <= '0;
				bank_q     <= '0;
				zrun_q     <= '0;
			end else if (cmd.turn_on) begin
				before_q <= reactive_power;
				induct_q <= induct_n;
				capac_q  <= capac_n;
			end else if (cmd.turn_off) begin
				if (status.measure_done) begin
					sum_q      <= '0;
					attempts_q <= '0;
					induct_q   <= '0;
					capac_q    <= '0;
					zrun_q     <= zrun_n;
					bank_q     <= status.last_bank ? '0 : bank_q + BANK_W'(1);
				end else begin
					sum_q      <= sum_n;
					attempts_q <= attempts_n;
					induct_q   <= induct_n;
					capac_q    <= capac_n;
				end
			end else if (cmd.settle) begin
				before_q <= reactive_power;
			end
		end
	end

	assign bank_ext = {4'b0000, bank_q};

	always_comb begin
		result             = '0;
		result.all_off     = cmd.clear | cmd.finish;
		result.done_res    = cmd.finish;
		result.switch_on   = cmd.turn_on;
		result.switch_off  = cmd.turn_off;
		result.kvar_peak   = largest_d;
		result.bank_count  = counted_d;
		if (cmd.turn_on || cmd.turn_off) begin
			result.bank_index = bank_ext[3:0];
		end
		if (cmd.turn_off && status.measure_done) begin
			result.value_valid = 1'b1;
			result.bank_value  = value;
		end
	end

endmodule

/* rtl/capacitor_bank_autoset_core.sv */
// top level of the capacitor bank autoset sequencer
//
// channel  | handshake                   | payload
// ---------+-----------------------------+------------------------------------------
// item     | item_valid / item_ready     | start_req, reactive_power, lagging
// result   | result_valid / result_ready | switch_on, switch_off, all_off, bank_index,
//          |                             | value_valid, bank_value, kvar_peak,
//          |                             | bank_count, done_res
//
// one tick per cycle while the output slot is free: a transfer is fully worked in the
// cycle it is taken, by the update of controller and datapath registers
// every tick gives exactly one result, held in an output register the cycle after
// the item is taken while a result waits unclaimed, the next item transfers in the same
// cycle the waiting one leaves; otherwise item_ready is low
// reset clears every sequencer register and the output valid flag
module capacitor_bank_autoset_core
	import cbas_pkg::*;
#(
	parameter int NUM_BANKS = DEFAULT_NUM_BANKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        start_req,
	input  logic [15:0] reactive_power,
	input  logic        lagging,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        switch_on,
	output logic        switch_off,
	output logic        all_off,
	output logic [3:0]  bank_index,
	output logic        value_valid,
	output logic [7:0]  bank_value,
	output logic [7:0]  kvar_peak,
	output logic [4:0]  bank_count,
	output logic        done_res
);

	cbas_cmd_t    cmd;
	cbas_status_t status;
	cbas_result_t result;
	cbas_result_t res_q;
	logic         valid_q;
	logic         fire;

	// output slot is free when empty or being drained this cycle
	assign item_ready = !valid_q || result_ready;
	assign fire       = item_valid && item_ready;

	cbas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.start_req (start_req),
		.status    (status),
		.cmd       (cmd)
	);

	cbas_dp #(
		.NUM_BANKS (NUM_BANKS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.reactive_power (reactive_power),
		.lagging        (lagging),
		.status         (status),
		.result         (result)
	);

	// result register, control flag only is reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= result;
		end
	end

	assign result_valid = valid_q;
	assign switch_on    = res_q.switch_on;
	assign switch_off   = res_q.switch_off;
	assign all_off      = res_q.all_off;
	assign bank_index   = res_q.bank_index;
	assign value_valid  = res_q.value_valid;
	assign bank_value   = res_q.bank_value;
	assign kvar_peak    = res_q.kvar_peak;
	assign bank_count   = res_q.bank_count;
	assign done_res     = res_q.done_res;

endmodule

/* tb/capacitor_bank_autoset_checker.sv */
// result predictor and comparator for the capacitor bank autoset sequencer
module capacitor_bank_autoset_checker
	import cbas_pkg::*;
#(
	parameter int NUM_BANKS = DEFAULT_NUM_BANKS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic        start_req,
	input  logic [15:0] reactive_power,
	input  logic        lagging,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic        switch_on,
	input  logic        switch_off,
	input  logic        all_off,
	input  logic [3:0]  bank_index,
	input  logic        value_valid,
	input  logic [7:0]  bank_value,
	input  logic [7:0]  kvar_peak,
	input  logic [4:0]  bank_count,
	input  logic        done_res,
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {SEQ_IDLE, SEQ_RUN, SEQ_FINISH} seq_step_t;

	seq_step_t    seq_step;
	logic [3:0]   settle_left;
	logic [1:0]   test_phase;
	int           bank_ptr;
	logic [2:0]   tries;
	logic [13:0]  size_sum;
	logic [15:0]  level_before;
	logic [15:0]  inductive_level;
	logic [15:0]  capacitive_level;
	logic [7:0]   bank_sizes [NUM_BANKS];
	logic [4:0]   banks_counted;
	logic [7:0]   peak_kvar;

	cbas_result_t awaited_results [$];
	cbas_result_t predicted;
	cbas_result_t want;
	int           fail_tally = 0;

	task automatic clear_sequencer();
		settle_left = '0;
		test_phase = '0;
		bank_ptr = 0;
		tries = '0;
		size_sum = '0;
		level_before = '0;
		inductive_level = '0;
		capacitive_level = '0;
		banks_counted = '0;
		peak_kvar = '0;
		foreach (bank_sizes[b]) bank_sizes[b] = '0;
	endtask

	task automatic take_reading(input logic [15:0] rp, input logic lag);
		if (lag) inductive_level = rp;
		else capacitive_level = rp;
	endtask

	// one tick of the sequencer: updates the mirrored state, returns the commands
	task automatic sequence_tick(input logic start, input logic [15:0] rp, input logic lag,
			output cbas_result_t res);
		logic [15:0] level_sum;
		logic [15:0] change;
		logic [11:0] delta;
		int          avg;
		bit          trimming;
		res = '0;
		if (start) begin
			clear_sequencer();
			settle_left = TIMER_SETTLE;
			seq_step = SEQ_RUN;
			res.all_off = 1'b1;
		end else if (seq_step == SEQ_RUN) begin
			if (settle_left != 0) begin
				settle_left = settle_left - 4'd1;
			end else if (test_phase == 2'd0) begin
				settle_left = TIMER_MEASURE;
				level_before = rp;
				take_reading(rp, lag);
				test_phase = 2'd1;
				res.switch_on = 1'b1;
				res.bank_index = bank_ptr[3:0];
			end else if (test_phase == 2'd1) begin
				take_reading(rp, lag);
				level_sum = capacitive_level + inductive_level;
				change = (level_sum > level_before) ? level_sum - level_before
					: level_before - level_sum;
				delta = change[15:4];
				// a null reading is charged two extra attempts
				if (delta == 0) tries = tries + 3'd2;
				size_sum = size_sum + {2'b00, delta};
				tries = tries + 3'd1;
				res.switch_off = 1'b1;
				res.bank_index = bank_ptr[3:0];
				settle_left = TIMER_SETTLE;
				if (tries >= ATTEMPT_LIMIT) begin
					avg = int'(size_sum) / 4;
					if (avg > int'(VALUE_CAP)) avg = int'(VALUE_CAP);
					if (bank_ptr < NUM_BANKS) bank_sizes[bank_ptr] = avg[7:0];
					res.value_valid = 1'b1;
					res.bank_value = avg[7:0];
					if (banks_counted < COUNT_MAX) banks_counted = banks_counted + 5'd1;
					if (int'(peak_kvar) < avg * 2)
						peak_kvar = (avg < int'(LARGE_LIMIT)) ? 8'(avg * 2) : 8'd0;
					size_sum = '0;
					test_phase = 2'd2;
					tries = '0;
					inductive_level = '0;
					capacitive_level = '0;
					bank_ptr++;
					if (bank_ptr >= NUM_BANKS) begin
						// drop trailing empty banks, bank zero always stays
						trimming = 1'b1;
						for (int b = NUM_BANKS - 1; b > 0; b--) begin
							if (bank_sizes[b] != 0) trimming = 1'b0;
							if (trimming && banks_counted > 0) banks_counted = banks_counted - 5'd1;
						end
						bank_ptr = 0;
						seq_step = SEQ_FINISH;
					end
				end else begin
					test_phase = 2'd0;
				end
			end else begin
				test_phase = 2'd0;
				level_before = rp;
				settle_left = TIMER_SETTLE;
			end
		end else if (seq_step == SEQ_FINISH) begin
			res.all_off = 1'b1;
			res.done_res = 1'b1;
			seq_step = SEQ_IDLE;
		end else begin
			seq_step = SEQ_IDLE;
		end
		res.kvar_peak = peak_kvar;
		res.bank_count = banks_counted;
	endtask

	function automatic int field_mismatch(input string name, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_sequencer();
			seq_step = SEQ_IDLE;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			// a result leaving now belongs to an earlier tick, so pop before push
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result transfer with no tick waiting for it");
					fail_tally++;
				end else begin
					want = awaited_results.pop_front();
					fail_tally += field_mismatch("switch_on", 16'(want.switch_on),
						16'(switch_on));
					fail_tally += field_mismatch("switch_off", 16'(want.switch_off),
						16'(switch_off));
					fail_tally += field_mismatch("all_off", 16'(want.all_off), 16'(all_off));
					fail_tally += field_mismatch("bank_index", 16'(want.bank_index),
						16'(bank_index));
					fail_tally += field_mismatch("value_valid", 16'(want.value_valid),
						16'(value_valid));
					fail_tally += field_mismatch("bank_value", 16'(want.bank_value),
						16'(bank_value));
					fail_tally += field_mismatch("kvar_peak", 16'(want.kvar_peak),
						16'(kvar_peak));
					fail_tally += field_mismatch("bank_count", 16'(want.bank_count),
						16'(bank_count));
					fail_tally += field_mismatch("done_res", 16'(want.done_res), 16'(done_res));
				end
			end
			if (item_valid && item_ready) begin
				sequence_tick(start_req, reactive_power, lagging, predicted);
				awaited_results.push_back(predicted);
			end
			outstanding <= awaited_results.size();
			mismatches <= fail_tally;
		end
	end

endmodule

/* tb/tb_capacitor_bank_autoset_core.sv */
// testbench top of the capacitor bank autoset sequencer: stimulus and verdict
module tb_capacitor_bank_autoset_core
	import cbas_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_TICKS = 1152;
	localparam int PHASE_TICKS = RANDOM_TICKS / 4;
	localparam int HOLD_CYCLES = 300;

	// how the power reading behaves over a stretch of ticks
	typedef enum int {LEVEL_STEADY, LEVEL_JITTER, LEVEL_NOISE, LEVEL_EXTREME} level_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        start_req = 1'b0;
	logic [15:0] reactive_power = '0;
	logic        lagging = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        switch_on;
	logic        switch_off;
	logic        all_off;
	logic [3:0]  bank_index;
	logic        value_valid;
	logic [7:0]  bank_value;
	logic [7:0]  kvar_peak;
	logic [4:0]  bank_count;
	logic        done_res;

	// fed back from the checker
	int mismatches;
	int outstanding;

	// idling per phase: none, sender only, receiver only, both
	int send_idle_by_phase [4] = '{0, 75, 0, 22};
	int stall_by_phase [4] = '{0, 0, 75, 22};
	int send_idle_pct = 0;
	int stall_pct = 0;

	// long receiver hold-off: the main thread bumps the request, the receiver counts
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	// finished runs seen on the result channel, used to kick off the next run
	int done_seen = 0;
	int done_used = 0;

	// current stretch of the random power profile
	level_mode_t seg_mode = LEVEL_STEADY;
	int          seg_left = 0;
	logic [15:0] seg_level = '0;
	logic        seg_lag = 1'b0;

	always #6 clk = ~clk;

	capacitor_bank_autoset_core uut (.*);

	capacitor_bank_autoset_checker #(.NUM_BANKS(DEFAULT_NUM_BANKS)) u_checker (.*);

	always @(posedge clk)
		if (result_valid && result_ready && done_res) done_seen <= done_seen + 1;

	// receiver: random stalls, or a long hold-off when one is requested
	initial begin
		forever begin
			@(posedge clk);
			if (hold_seq != hold_seen) begin
				hold_seen = hold_seq;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// present one tick, with a random idle gap ahead of it, and wait for its transfer
	task automatic offer_tick(input logic start, input logic [15:0] rp, input logic lag);
		if ($urandom_range(99) < send_idle_pct) begin
			if (item_valid) item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		start_req <= start;
		reactive_power <= rp;
		lagging <= lag;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	// stop offering and wait until every predicted result has been taken
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// random tick: the reading follows a profile held over a stretch of ticks so that
	// null and real measurements both happen; a finished run is restarted
	task automatic random_tick();
		logic [15:0] rp;
		logic        lag;
		logic        start;
		if (seg_left == 0) begin
			// steady readings give null measurements and short banks, so favor them
			seg_mode = ($urandom_range(9) < 4) ? LEVEL_STEADY : level_mode_t'($urandom_range(3));
			seg_left = $urandom_range(60, 8);
			seg_level = 16'($urandom);
			seg_lag = 1'($urandom_range(1));
		end
		seg_left--;
		case (seg_mode)
			LEVEL_STEADY: begin
				rp = seg_level;
				lag = seg_lag;
			end
			LEVEL_JITTER: begin
				// small wander around the level, straddling up to two measurement steps
				rp = seg_level + 16'($urandom_range(40));
				lag = seg_lag;
			end
			LEVEL_NOISE: begin
				rp = 16'($urandom);
				lag = 1'($urandom_range(1));
			end
			default: begin
				rp = $urandom_range(1) ? 16'hFFFF : 16'h0000;
				lag = 1'($urandom_range(1));
			end
		endcase
		// rare restart in the middle of a run, always one after a finished run
		start = ($urandom_range(399) == 0);
		if (done_seen != done_used) begin
			done_used = done_seen;
			start = 1'b1;
		end
		offer_tick(start, rp, lag);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// ticks before any start do nothing
		offer_tick(1'b0, 16'h0000, 1'b0);
		offer_tick(1'b0, 16'hFFFF, 1'b1);
		// start: all banks off, then the settle countdown ignores the readings
		offer_tick(1'b1, 16'hFFFF, 1'b1);
		repeat (5) offer_tick(1'b0, 16'($urandom), 1'($urandom_range(1)));
		// bank zero on with a full-scale inductive reading
		offer_tick(1'b0, 16'hFFFF, 1'b1);
		repeat (8) offer_tick(1'b0, 16'h0000, 1'b0);
		// capacitive reading that wraps the power sum to zero
		offer_tick(1'b0, 16'h0001, 1'b0);
		repeat (4) offer_tick(1'b0, 16'h0000, 1'b1);
		// start takes priority in the middle of a run
		offer_tick(1'b1, 16'h8000, 1'b0);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_idle_by_phase[ph];
			stall_pct <= stall_by_phase[ph];
			for (int n = 0; n < PHASE_TICKS; n++) begin
				// receiver holds off while the sender keeps pushing, filling the block
				if (ph == 0 && n == 40) hold_seq <= hold_seq + 1;
				random_tick();
			end
			// sender pauses until all results are in before the next phase
			drain();
		end

		// the block holds at most one result
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
